// ===== rtl/per_cell_running_mean_variance_assert.svh =====
// assertion macros shared by the rtl
`ifndef PER_CELL_RUNNING_MEAN_VARIANCE_ASSERT_SVH
`define PER_CELL_RUNNING_MEAN_VARIANCE_ASSERT_SVH

// same-cycle implication
`define PCRMV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcrmv same-cycle check failed");

// next-cycle implication
`define PCRMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcrmv next-cycle check failed");

`endif

// ===== rtl/pcrmv_pkg.sv =====
package pcrmv_pkg;

	localparam int CELLS_DEF = 4096;
	localparam int QUANT_DEF = 16;
	localparam int QDEPTH = 4;
	localparam int MQ_W = 33;
	localparam int MDVD_W = 63;
	localparam int VQ_W = 64;
	localparam logic [31:0] N_MAX = 32'hFFFF_FFFF;
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	typedef struct packed {
		logic [11:0] cidx;
		logic [3:0]  qty;
		logic [31:0] x;
		logic [31:0] n;
	} work_t;

	typedef struct packed {
		logic [11:0] cidx;
		logic [3:0]  qty;
		logic [31:0] x;
		logic [31:0] om;
		logic [63:0] dev;
		logic        neg;
		logic [31:0] n;
	} mpay_t;

	typedef struct packed {
		logic [11:0] cidx;
		logic [3:0]  qty;
		logic [31:0] mean;
	} vpay_t;

endpackage

// ===== rtl/pcrmv_sample_if.sv =====
interface pcrmv_sample_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [11:0] cell_req;
	logic [3:0]  quantity;
	logic [31:0] sample;

	modport source (output valid, func, cell_req, quantity, sample, input ready);
	modport sink (input valid, func, cell_req, quantity, sample, output ready);
endinterface

// ===== rtl/pcrmv_result_if.sv =====
interface pcrmv_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_cell;
	logic [3:0]  out_quantity;
	logic [31:0] mean;
	logic [62:0] variance;

	modport source (output valid, out_cell, out_quantity, mean, variance, input ready);
	modport sink (input valid, out_cell, out_quantity, mean, variance, output ready);
endinterface

// ===== rtl/per_cell_running_mean_variance.sv =====
// Running mean and variance per (cell, quantity) entry by Welford's update.
// A sample word is taken each cycle while the queue is not full and the
// clearing pass is over; its result passes 3 read and multiply stages, a
// 33-stage mean divider, 3 deviation stages, a 64-stage variance divider
// and the output register. A sample whose entry is still among the 38
// stages before its write-back waits in the queue until that write lands,
// so repeated hits on one entry go through one at a time. End-of-timestep
// words give no result. After reset a clearing pass over CELLS*QUANTITIES
// entries (65536 by default) zeroes the stores; no word is taken till then.
module per_cell_running_mean_variance #(
	parameter int CELLS = pcrmv_pkg::CELLS_DEF,
	parameter int QUANTITIES = pcrmv_pkg::QUANT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	pcrmv_sample_if.sink   in_ch,
	pcrmv_result_if.source out_ch
);
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_valid;
	logic             busy;
	pcrmv_pkg::work_t wdata;
	pcrmv_pkg::work_t hd;

	pcrmv_front #(
		.CELLS(CELLS),
		.QUANTITIES(QUANTITIES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.busy(busy),
		.q_full(q_full),
		.push(push),
		.wdata(wdata)
	);

	pcrmv_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(wdata),
		.pop(pop),
		.rdata(hd),
		.nonempty(q_valid),
		.full(q_full)
	);

	pcrmv_back #(
		.CELLS(CELLS),
		.QUANTITIES(QUANTITIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.hd(hd),
		.pop(pop),
		.busy(busy),
		.out_ch(out_ch)
	);
endmodule

// ===== rtl/pcrmv_queue.sv =====
`include "per_cell_running_mean_variance_assert.svh"

module pcrmv_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcrmv_pkg::work_t  wdata,
	input  logic              pop,
	output pcrmv_pkg::work_t  rdata,
	output logic              nonempty,
	output logic              full
);
	localparam int DEPTH = pcrmv_pkg::QDEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pcrmv_pkg::work_t slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign nonempty = (cnt_q != '0);
	assign full = (cnt_q == CW'(DEPTH));
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	`PCRMV_ASSERT_SAME(a_no_overflow, clk, arst_n, full, !push)
	`PCRMV_ASSERT_SAME(a_no_underflow, clk, arst_n, pop, nonempty)
endmodule

// ===== rtl/pcrmv_front.sv =====
`include "per_cell_running_mean_variance_assert.svh"

module pcrmv_front #(
	parameter int CELLS = pcrmv_pkg::CELLS_DEF,
	parameter int QUANTITIES = pcrmv_pkg::QUANT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pcrmv_sample_if.sink      in_ch,
	input  logic              busy,
	input  logic              q_full,
	output logic              push,
	output pcrmv_pkg::work_t  wdata
);
	logic [31:0] n_q;
	logic        acc;
	logic        step_acc;
	logic        in_range;

	assign in_ch.ready = !busy && !q_full;
	assign acc = in_ch.valid && in_ch.ready;
	assign step_acc = acc && (in_ch.func == pcrmv_pkg::FUNC_STEP);
	assign in_range = (32'(in_ch.cell_req) < 32'(CELLS))
		&& (32'(in_ch.quantity) < 32'(QUANTITIES));
	assign push = acc && (in_ch.func == pcrmv_pkg::FUNC_SAMPLE) && in_range;

	assign wdata.cidx = in_ch.cell_req;
	assign wdata.qty = in_ch.quantity;
	assign wdata.x = in_ch.sample;
	assign wdata.n = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 32'd1;
		end else if (step_acc && (n_q != pcrmv_pkg::N_MAX)) begin
			n_q <= n_q + 32'd1;
		end
	end

	`PCRMV_ASSERT_NEXT(a_step_inc, clk, arst_n, step_acc && (n_q != pcrmv_pkg::N_MAX), n_q == $past(n_q) + 32'd1)
endmodule

// ===== rtl/pcrmv_div.sv =====
module pcrmv_div #(
	parameter int DVD_W = 64,
	parameter int DVS_W = 32,
	parameter int Q_W = 64,
	parameter int PAY_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [DVD_W-1:0] in_dvd,
	input  logic [DVS_W-1:0] in_dvs,
	input  logic [PAY_W-1:0] in_pay,
	output logic             out_v,
	output logic [Q_W-1:0]   out_q,
	output logic [PAY_W-1:0] out_pay
);
	localparam int R_W = DVS_W + 1;

	logic [Q_W-1:0]   v_q;
	logic [R_W-1:0]   r_q   [Q_W];
	logic [Q_W-1:0]   lo_q  [Q_W];
	logic [Q_W-1:0]   qb_q  [Q_W];
	logic [DVS_W-1:0] dvs_q [Q_W];
	logic [PAY_W-1:0] pay_q [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_st
		logic [R_W-1:0]   r_p;
		logic [Q_W-1:0]   lo_p;
		logic [Q_W-1:0]   qb_p;
		logic [DVS_W-1:0] d_p;
		logic [PAY_W-1:0] y_p;
		logic             v_p;
		logic [R_W-1:0]   t;
		logic             ge;

		if (k == 0) begin : g_first
			assign r_p = R_W'(in_dvd >> Q_W);
			assign lo_p = in_dvd[Q_W-1:0];
			assign qb_p = '0;
			assign d_p = in_dvs;
			assign y_p = in_pay;
			assign v_p = in_v;
		end else begin : g_next
			assign r_p = r_q[k-1];
			assign lo_p = lo_q[k-1];
			assign qb_p = qb_q[k-1];
			assign d_p = dvs_q[k-1];
			assign y_p = pay_q[k-1];
			assign v_p = v_q[k-1];
		end

		assign t = {r_p[R_W-2:0], lo_p[Q_W-1-k]};
		assign ge = (t >= {1'b0, d_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k] <= ge ? (t - {1'b0, d_p}) : t;
				lo_q[k] <= lo_p;
				qb_q[k] <= {qb_p[Q_W-2:0], ge};
				dvs_q[k] <= d_p;
				pay_q[k] <= y_p;
			end
		end
	end

	assign out_v = v_q[Q_W-1];
	assign out_q = qb_q[Q_W-1];
	assign out_pay = pay_q[Q_W-1];
endmodule

// ===== rtl/pcrmv_back.sv =====
`include "per_cell_running_mean_variance_assert.svh"

module pcrmv_back #(
	parameter int CELLS = pcrmv_pkg::CELLS_DEF,
	parameter int QUANTITIES = pcrmv_pkg::QUANT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  pcrmv_pkg::work_t  hd,
	output logic              pop,
	output logic              busy,
	pcrmv_result_if.source    out_ch
);
	localparam int ENTRIES = CELLS * QUANTITIES;
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MQ = pcrmv_pkg::MQ_W;
	localparam int HZ = 5 + MQ;

	logic [31:0] mean_mem [ENTRIES];
	logic [63:0] dev_mem [ENTRIES];

	logic          busy_q;
	logic [AW-1:0] clr_q;
	logic          adv;
	logic          hit;
	logic          iss;
	logic [AW-1:0] hd_addr;

	logic [HZ-1:0] hz_v;
	logic [AW-1:0] hz_a [HZ];

	pcrmv_pkg::work_t w_s1, w_s2, w_s3;
	logic [31:0] om_s1, om_s2, om_s3;
	logic [63:0] dev_s1, dev_s2, dev_s3;
	logic signed [64:0] mprod_s2;
	logic        neg_s3;
	logic [62:0] mag_s3;

	logic signed [64:0] num;
	logic [64:0] num_mag;
	pcrmv_pkg::mpay_t md_in;
	pcrmv_pkg::mpay_t md_pay;
	logic          md_v;
	logic [MQ-1:0] md_q;

	logic [32:0] nm33, x33, om33, nmx33, d1, d2, m1, m2;
	logic        opp;
	pcrmv_pkg::mpay_t pay_s4;
	logic [31:0] nm_s4, m1_s4, m2_s4;
	logic        opp_s4;

	logic [63:0] prod_s5, dev_s5;
	logic [31:0] nm_s5, n_s5;
	logic [11:0] cell_s5;
	logic [3:0]  qty_s5;

	logic [64:0] sum;
	logic [63:0] acc;
	logic        wr_en;
	logic [AW-1:0] wr_a;

	logic        v_s6;
	logic [63:0] acc_s6;
	logic [31:0] n_s6;
	pcrmv_pkg::vpay_t vp_s6;
	pcrmv_pkg::vpay_t vd_pay;
	logic        vd_v;
	logic [pcrmv_pkg::VQ_W-1:0] vd_q;

	logic        out_v_q;
	logic [11:0] cell_q;
	logic [3:0]  qty_q;
	logic [31:0] mean_q;
	logic [62:0] var_q;

	assign adv = !out_v_q || out_ch.ready;
	assign busy = busy_q;
	assign hd_addr = AW'(32'(hd.cidx) * 32'(QUANTITIES) + 32'(hd.qty));

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < HZ; i++) begin
			if (hz_v[i] && (hz_a[i] == hd_addr)) begin
				hit = 1'b1;
			end
		end
	end

	assign iss = q_valid && adv && !busy_q && !hit;
	assign pop = iss;

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(ENTRIES - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hz_v <= '0;
		end else if (adv) begin
			hz_v <= {hz_v[HZ-2:0], iss};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hz_a[0] <= hd_addr;
			for (int i = 1; i < HZ; i++) begin
				hz_a[i] <= hz_a[i-1];
			end
		end
	end

	assign sum = {1'b0, dev_s5} + {1'b0, prod_s5};
	assign acc = sum[64] ? '1 : sum[63:0];
	assign wr_en = busy_q || (hz_v[HZ-1] && adv);
	assign wr_a = busy_q ? clr_q : hz_a[HZ-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mean_mem[wr_a] <= busy_q ? 32'd0 : nm_s5;
			dev_mem[wr_a] <= busy_q ? 64'd0 : acc;
		end
		if (adv) begin
			om_s1 <= mean_mem[hd_addr];
			dev_s1 <= dev_mem[hd_addr];
		end
	end

	assign num = mprod_s2 + $signed({{33{w_s2.x[31]}}, w_s2.x});
	assign num_mag = num[64] ? (65'd0 - num) : num;

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= hd;
			w_s2 <= w_s1;
			om_s2 <= om_s1;
			dev_s2 <= dev_s1;
			mprod_s2 <= $signed(om_s1) * $signed({1'b0, w_s1.n - 32'd1});
			w_s3 <= w_s2;
			om_s3 <= om_s2;
			dev_s3 <= dev_s2;
			neg_s3 <= num[64];
			mag_s3 <= num_mag[62:0];
		end
	end

	assign md_in.cidx = w_s3.cidx;
	assign md_in.qty = w_s3.qty;
	assign md_in.x = w_s3.x;
	assign md_in.om = om_s3;
	assign md_in.dev = dev_s3;
	assign md_in.neg = neg_s3;
	assign md_in.n = w_s3.n;

	pcrmv_div #(
		.DVD_W(pcrmv_pkg::MDVD_W),
		.DVS_W(32),
		.Q_W(MQ),
		.PAY_W($bits(pcrmv_pkg::mpay_t))
	) u_mdiv (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_v(hz_v[2]),
		.in_dvd(mag_s3),
		.in_dvs(w_s3.n),
		.in_pay(md_in),
		.out_v(md_v),
		.out_q(md_q),
		.out_pay(md_pay)
	);

	always_comb begin
		nm33 = md_pay.neg ? (33'd0 - 33'(md_q)) : 33'(md_q);
		x33 = {md_pay.x[31], md_pay.x};
		om33 = {md_pay.om[31], md_pay.om};
		nmx33 = {nm33[31], nm33[31:0]};
		d1 = x33 - om33;
		d2 = x33 - nmx33;
		opp = (d1[32] && (d2 != '0) && !d2[32]) || (d2[32] && (d1 != '0) && !d1[32]);
		m1 = d1[32] ? (33'd0 - d1) : d1;
		m2 = d2[32] ? (33'd0 - d2) : d2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s4 <= md_pay;
			nm_s4 <= nm33[31:0];
			m1_s4 <= m1[31:0];
			m2_s4 <= m2[31:0];
			opp_s4 <= opp;
			prod_s5 <= opp_s4 ? 64'd0 : ({32'd0, m1_s4} * {32'd0, m2_s4});
			dev_s5 <= pay_s4.dev;
			nm_s5 <= nm_s4;
			n_s5 <= pay_s4.n;
			cell_s5 <= pay_s4.cidx;
			qty_s5 <= pay_s4.qty;
			acc_s6 <= acc;
			n_s6 <= n_s5;
			vp_s6.cidx <= cell_s5;
			vp_s6.qty <= qty_s5;
			vp_s6.mean <= nm_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= hz_v[HZ-1];
		end
	end

	pcrmv_div #(
		.DVD_W(pcrmv_pkg::VQ_W),
		.DVS_W(32),
		.Q_W(pcrmv_pkg::VQ_W),
		.PAY_W($bits(pcrmv_pkg::vpay_t))
	) u_vdiv (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_v(v_s6),
		.in_dvd(acc_s6),
		.in_dvs(n_s6),
		.in_pay(vp_s6),
		.out_v(vd_v),
		.out_q(vd_q),
		.out_pay(vd_pay)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= vd_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_q <= vd_pay.cidx;
			qty_q <= vd_pay.qty;
			mean_q <= vd_pay.mean;
			var_q <= vd_q[63] ? '1 : vd_q[62:0];
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.out_cell = cell_q;
	assign out_ch.out_quantity = qty_q;
	assign out_ch.mean = mean_q;
	assign out_ch.variance = var_q;

	`PCRMV_ASSERT_SAME(a_hazard, clk, arst_n, hz_v[0] && hz_v[1], hz_a[0] != hz_a[1])
	`PCRMV_ASSERT_SAME(a_div_align, clk, arst_n, 1'b1, md_v == hz_v[HZ-3])
	`PCRMV_ASSERT_SAME(a_clear_idle, clk, arst_n, busy_q, !hz_v[0])
endmodule
